@@ rtl/core/wpe_pkg.sv @@
// Shared types and constants for the windowed poke edge detector.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none
package wpe_pkg;

	localparam int CHANNELS  = 6;
	localparam int CHAN_W    = 3;
	localparam int TIME_W    = 32;
	localparam int WIN_W     = 16;
	localparam int Q_DEPTH   = 4;
	localparam int Q_PTR_W   = $clog2(Q_DEPTH);
	localparam int S_DATA_W  = 40;
	localparam int M_DATA_W  = 72;
	localparam logic [WIN_W-1:0] WINDOW_RESET = WIN_W'(5);

	// One qualification check that changed at least one channel.
	typedef struct packed {
		logic [TIME_W-1:0]   now;
		logic [CHANNELS-1:0] change;
		logic [CHANNELS-1:0] seen;
	} wpe_task_t;

	// Queue status seen by the top level and the back.
	typedef struct packed {
		logic full;
		logic empty;
	} wpe_qstat_t;

endpackage
`default_nettype wire

@@ rtl/core/windowed_poke_edge_detector.sv @@
// With the back end idle, the first event beat of a sample passes the task queue and the back end's
// task registers into the output register; further events of the same sample follow one per cycle
// while the receiver is ready. Samples are taken every cycle while the 4-deep task queue has room;
// the back end drains one event beat per changed channel, one per cycle while the receiver is ready.
// Reset (arst_n low, asynchronous): latches, levels, check time and entry times clear,
// window_ms returns to 5, queue and output register empty.
`timescale 1ns / 1ps
`default_nettype none
module windowed_poke_edge_detector (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	// window length register
	input  wire logic                             cfg_wr_en,
	input  wire logic [wpe_pkg::WIN_W-1:0]        cfg_wr_data,
	// sample stream
	input  wire logic                             s_tvalid,
	output      logic                             s_tready,
	input  wire logic [wpe_pkg::S_DATA_W-1:0]     s_tdata,  // sample_bits[5:0], now_ms[37:6]
	// event stream
	output      logic                             m_tvalid,
	input  wire logic                             m_tready,
	output      logic [wpe_pkg::M_DATA_W-1:0]     m_tdata,  // channel[2:0], event_time_ms[34:3],
	                                                         // held_ms[66:35]
	output      logic                             m_tuser,  // is_exit
	output      logic                             m_tlast
);

	logic                         s_accept;
	logic                         q_push;
	logic                         q_pop;
	wpe_pkg::wpe_task_t           q_wr;
	wpe_pkg::wpe_task_t           q_rd;
	wpe_pkg::wpe_qstat_t          q_stat;
	logic [wpe_pkg::CHAN_W-1:0]   ev_channel;
	logic [wpe_pkg::TIME_W-1:0]   ev_time;
	logic [wpe_pkg::TIME_W-1:0]   ev_held;

	// Hold off samples only when the queue is full; a sample whose check changes
	// nothing never needs a slot, but stall anyway to keep ready simple.
	assign s_tready = !q_stat.full;
	assign s_accept = s_tvalid && s_tready;

	// Front: accumulate latches, run the window check, classify changes.
	wpe_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.accept      (s_accept),
		.sample_bits (s_tdata[wpe_pkg::CHANNELS-1:0]),
		.now_ms      (s_tdata[wpe_pkg::CHANNELS +: wpe_pkg::TIME_W]),
		.push        (q_push),
		.task_d      (q_wr)
	);

	// Queue: decouple sample acceptance from event draining.
	wpe_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.wr_task (q_wr),
		.pop     (q_pop),
		.rd_task (q_rd),
		.stat    (q_stat)
	);

	// Back: emit one event beat per changed channel, in channel order.
	wpe_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head          (q_rd),
		.qstat         (q_stat),
		.pop           (q_pop),
		.out_valid     (m_tvalid),
		.out_ready     (m_tready),
		.channel       (ev_channel),
		.is_exit       (m_tuser),
		.event_time_ms (ev_time),
		.held_ms       (ev_held),
		.last          (m_tlast)
	);

	// Pack the event beat; pad the top bits with zeros.
	assign m_tdata = {{(wpe_pkg::M_DATA_W - wpe_pkg::CHAN_W - 2*wpe_pkg::TIME_W){1'b0}},
	                  ev_held, ev_time, ev_channel};

`ifndef ASSERT_OFF
	// never write into a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_stat.full)
		else $error("task queue overflow");

	// never pop an empty queue
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_stat.empty)
		else $error("task queue underflow");

	// events of one sample leave without gaps
	a_burst_gapless: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && !m_tlast) |=> m_tvalid)
		else $error("gap inside an event burst");

	// channel index stays in range
	a_channel_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[wpe_pkg::CHAN_W-1:0] < wpe_pkg::CHAN_W'(wpe_pkg::CHANNELS)))
		else $error("event channel out of range");
`endif

endmodule
`default_nettype wire

@@ rtl/core/wpe_front.sv @@
// Front part: sample accumulation, window check and change classification.
// Depends on wpe_pkg; pushes one task per changing check into wpe_fifo.
`timescale 1ns / 1ps
`default_nettype none
module wpe_front (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_wr_en,
	input  wire logic [wpe_pkg::WIN_W-1:0]           cfg_wr_data,
	input  wire logic                                accept,
	input  wire logic [wpe_pkg::CHANNELS-1:0]        sample_bits,
	input  wire logic [wpe_pkg::TIME_W-1:0]          now_ms,
	output      logic                                push,
	output      wpe_pkg::wpe_task_t                  task_d
);

	logic [wpe_pkg::WIN_W-1:0]    window_q;
	logic [wpe_pkg::CHANNELS-1:0] latch_q;
	logic [wpe_pkg::CHANNELS-1:0] qual_q;
	logic [wpe_pkg::TIME_W-1:0]   last_check_q;
	logic [wpe_pkg::CHANNELS-1:0] latch_next;
	logic [wpe_pkg::TIME_W-1:0]   since;
	logic                         due;

	always_comb begin
		latch_next    = latch_q | sample_bits;
		since         = now_ms - last_check_q;
		due           = since >= {{(wpe_pkg::TIME_W-wpe_pkg::WIN_W){1'b0}}, window_q};
		task_d.now    = now_ms;
		task_d.seen   = latch_next;
		task_d.change = latch_next ^ qual_q;
		push          = accept && due && (task_d.change != '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q     <= wpe_pkg::WINDOW_RESET;
			latch_q      <= '0;
			qual_q       <= '0;
			last_check_q <= '0;
		end else begin
			if (cfg_wr_en) begin
				window_q <= cfg_wr_data;
			end
			if (accept) begin
				if (due) begin
					// qualify: latched level becomes the new level, restart latching
					last_check_q <= now_ms;
					qual_q       <= latch_next;
					latch_q      <= '0;
				end else begin
					latch_q <= latch_next;
				end
			end
		end
	end

endmodule
`default_nettype wire

@@ rtl/core/wpe_fifo.sv @@
// Short task queue between the front and back parts.
// Depends on wpe_pkg for the task type and depth.
`timescale 1ns / 1ps
`default_nettype none
module wpe_fifo (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	input  wire wpe_pkg::wpe_task_t wr_task,
	input  wire logic               pop,
	output wpe_pkg::wpe_task_t      rd_task,
	output wpe_pkg::wpe_qstat_t     stat
);

	wpe_pkg::wpe_task_t           mem_q [wpe_pkg::Q_DEPTH];
	logic [wpe_pkg::Q_PTR_W-1:0]  wr_ptr_q;
	logic [wpe_pkg::Q_PTR_W-1:0]  rd_ptr_q;
	logic [wpe_pkg::Q_PTR_W:0]    count_q;

	assign stat.full  = (count_q == (wpe_pkg::Q_PTR_W+1)'(wpe_pkg::Q_DEPTH));
	assign stat.empty = (count_q == '0);
	assign rd_task    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_task;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

@@ rtl/core/wpe_back.sv @@
// Back part: walks the changed channels of a task, one event beat per cycle while the output
// is not stalled, keeps entry times and drives the output register. Depends on wpe_pkg.
`timescale 1ns / 1ps
`default_nettype none
module wpe_back (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire wpe_pkg::wpe_task_t            head,
	input  wire wpe_pkg::wpe_qstat_t           qstat,
	output      logic                          pop,
	output      logic                          out_valid,
	input  wire logic                          out_ready,
	output      logic [wpe_pkg::CHAN_W-1:0]    channel,
	output      logic                          is_exit,
	output      logic [wpe_pkg::TIME_W-1:0]    event_time_ms,
	output      logic [wpe_pkg::TIME_W-1:0]    held_ms,
	output      logic                          last
);

	logic                         busy_q;
	logic [wpe_pkg::CHANNELS-1:0] mask_q;
	logic [wpe_pkg::CHANNELS-1:0] seen_q;
	logic [wpe_pkg::TIME_W-1:0]   now_q;
	logic [wpe_pkg::TIME_W-1:0]   entry_q [wpe_pkg::CHANNELS];
	logic                         out_valid_q;
	logic [wpe_pkg::CHAN_W-1:0]   channel_q;
	logic                         is_exit_q;
	logic [wpe_pkg::TIME_W-1:0]   event_time_q;
	logic [wpe_pkg::TIME_W-1:0]   held_q;
	logic                         last_q;

	logic [wpe_pkg::CHAN_W-1:0]   idx;
	logic [wpe_pkg::CHANNELS-1:0] rest;
	logic                         adv;

	// lowest pending channel goes first
	always_comb begin
		idx = '0;
		for (int i = wpe_pkg::CHANNELS - 1; i >= 0; i--) begin
			if (mask_q[i]) begin
				idx = wpe_pkg::CHAN_W'(i);
			end
		end
		rest = mask_q;
		for (int i = 0; i < wpe_pkg::CHANNELS; i++) begin
			if (wpe_pkg::CHAN_W'(i) == idx) begin
				rest[i] = 1'b0;
			end
		end
		adv = busy_q && (!out_valid_q || out_ready);
		pop = !qstat.empty && (!busy_q || (adv && (rest == '0)));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			mask_q      <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < wpe_pkg::CHANNELS; i++) begin
				entry_q[i] <= '0;
			end
		end else begin
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (adv && seen_q[idx]) begin
				entry_q[idx] <= now_q;
			end
			if (pop) begin
				busy_q <= 1'b1;
				mask_q <= head.change;
			end else if (adv) begin
				busy_q <= (rest != '0);
				mask_q <= rest;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			seen_q <= head.seen;
			now_q  <= head.now;
		end
		if (adv) begin
			channel_q    <= idx;
			is_exit_q    <= !seen_q[idx];
			event_time_q <= now_q;
			held_q       <= seen_q[idx] ? '0 : (now_q - entry_q[idx]);
			last_q       <= (rest == '0);
		end
	end

	assign out_valid     = out_valid_q;
	assign channel       = channel_q;
	assign is_exit       = is_exit_q;
	assign event_time_ms = event_time_q;
	assign held_ms       = held_q;
	assign last          = last_q;

endmodule
`default_nettype wire

@@ bench/wpe_event_checker.sv @@
// Event checker for the windowed poke edge detector: watches the config, sample and event
// channels, predicts the event beats of each sample and compares them field by field.
// Depends on wpe_pkg for widths and the reset window length.
`timescale 1ns / 1ps
module wpe_event_checker (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_wr_en,
	input  wire logic [wpe_pkg::WIN_W-1:0]    cfg_wr_data,
	input  wire logic                         s_tvalid,
	input  wire logic                         s_tready,
	input  wire logic [wpe_pkg::S_DATA_W-1:0] s_tdata,  // sample_bits, now_ms
	input  wire logic                         m_tvalid,
	input  wire logic                         m_tready,
	input  wire logic [wpe_pkg::M_DATA_W-1:0] m_tdata,  // channel, event_time_ms, held_ms
	input  wire logic                         m_tuser,  // is_exit
	input  wire logic                         m_tlast,
	output int                                mismatches,
	output int                                events_waiting
);
	import wpe_pkg::*;

	localparam logic KIND_ENTRY = 1'b0;
	localparam logic KIND_EXIT  = 1'b1;

	typedef struct packed {
		logic [CHAN_W-1:0] channel;
		logic              is_exit;
		logic [TIME_W-1:0] event_time;
		logic [TIME_W-1:0] held;
		logic              last;
	} poke_event_t;

	logic [WIN_W-1:0]    window;
	logic [CHANNELS-1:0] latched;
	logic [CHANNELS-1:0] level;
	logic [TIME_W-1:0]   check_time;
	logic [TIME_W-1:0]   entered_at [CHANNELS];
	poke_event_t         expected_events [$];
	int                  errors = 0;

	// Latch the sample; on a due window check, queue one event per changed channel.
	task automatic qualify_sample(input logic [CHANNELS-1:0] bits, input logic [TIME_W-1:0] now);
		logic [TIME_W-1:0] gap;
		poke_event_t       ev;
		poke_event_t       held_back;
		logic              have_one;
		have_one = 1'b0;
		held_back = '0;
		latched = latched | bits;
		gap = now - check_time;
		if (gap < TIME_W'(window))
			return;
		check_time = now;
		for (int ch = 0; ch < CHANNELS; ch++) begin
			if (latched[ch] != level[ch]) begin
				ev = '0;
				ev.channel = CHAN_W'(ch);
				ev.event_time = now;
				if (latched[ch]) begin
					level[ch] = 1'b1;
					entered_at[ch] = now;
					ev.is_exit = KIND_ENTRY;
				end else begin
					level[ch] = 1'b0;
					ev.is_exit = KIND_EXIT;
					ev.held = now - entered_at[ch];
				end
				// hold each event back one step so the final one can carry last
				if (have_one)
					expected_events.push_back(held_back);
				held_back = ev;
				have_one = 1'b1;
			end
		end
		if (have_one) begin
			held_back.last = 1'b1;
			expected_events.push_back(held_back);
		end
		latched = '0;
	endtask

	function automatic int field_err(input string name, input logic [TIME_W-1:0] want,
	                                 input logic [TIME_W-1:0] got);
		if (want === got)
			return 0;
		$display("%0t ns: event %s mismatch, expected %0h, actual %0h", $time, name, want, got);
		return 1;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		poke_event_t want;
		if (!arst_n) begin
			window = WINDOW_RESET;
			latched = '0;
			level = '0;
			check_time = '0;
			for (int ch = 0; ch < CHANNELS; ch++)
				entered_at[ch] = '0;
			expected_events.delete();
		end else begin
			if (cfg_wr_en)
				window = cfg_wr_data;
			// events leave only after their sample has passed the task queue, so check first
			if (m_tvalid && m_tready) begin
				if (expected_events.size() == 0) begin
					$display("%0t ns: unexpected event beat, expected none, actual tdata %0h last %0b",
						$time, m_tdata, m_tlast);
					errors++;
				end else begin
					want = expected_events.pop_front();
					errors += field_err("channel", TIME_W'(want.channel), TIME_W'(m_tdata[CHAN_W-1:0]));
					errors += field_err("is_exit", TIME_W'(want.is_exit), TIME_W'(m_tuser));
					errors += field_err("event_time_ms", want.event_time, m_tdata[CHAN_W +: TIME_W]);
					errors += field_err("held_ms", want.held, m_tdata[CHAN_W+TIME_W +: TIME_W]);
					errors += field_err("last", TIME_W'(want.last), TIME_W'(m_tlast));
				end
			end
			if (s_tvalid && s_tready)
				qualify_sample(s_tdata[CHANNELS-1:0], s_tdata[CHANNELS +: TIME_W]);
		end
		events_waiting <= expected_events.size();
		mismatches <= errors;
	end

endmodule

@@ bench/tb_top.sv @@
// Top of the windowed poke edge detector bench: clock, reset, window writes, sample stimulus
// and receiver stalls. Depends on wpe_pkg, the block and wpe_event_checker.
`timescale 1ns / 1ps
module tb_top;
	import wpe_pkg::*;

	logic                clk         = 1'b0;
	logic                arst_n      = 1'b0;
	logic                cfg_wr_en   = 1'b0;
	logic [WIN_W-1:0]    cfg_wr_data = '0;
	logic                s_tvalid    = 1'b0;
	logic                s_tready;
	logic [S_DATA_W-1:0] s_tdata     = '0;  // sample_bits[5:0], now_ms[37:6], zero pad
	logic                m_tvalid;
	logic                m_tready    = 1'b0;
	logic [M_DATA_W-1:0] m_tdata;           // channel[2:0], event_time_ms[34:3], held_ms[66:35]
	logic                m_tuser;           // is_exit
	logic                m_tlast;
	int                  mismatches;
	int                  events_waiting;

	// Idling odds out of a hundred, changed per phase.
	int                  send_idle_pct = 0;
	int                  recv_stall_pct = 0;

	// Stimulus timeline: the running millisecond counter and the window the block holds.
	logic [TIME_W-1:0]   clock_ms = '0;
	int                  win = WINDOW_RESET;
	logic [CHANNELS-1:0] prev_bits = '0;

	int                  phase_idle  [4] = '{0, 77, 0, 15};
	int                  phase_stall [4] = '{0, 0, 77, 15};

	localparam int ITEMS_PER_PHASE = 115;
	localparam int SETTLE_CYCLES   = 8;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	windowed_poke_edge_detector DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.m_tlast     (m_tlast)
	);

	wpe_event_checker poke_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data),
		.s_tvalid       (s_tvalid),
		.s_tready       (s_tready),
		.s_tdata        (s_tdata),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.m_tdata        (m_tdata),
		.m_tuser        (m_tuser),
		.m_tlast        (m_tlast),
		.mismatches     (mismatches),
		.events_waiting (events_waiting)
	);

	// Event receiver: stall at random with the current odds, one decision per edge.
	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Offer one sample beat and return at the edge that takes it. Any idle gap comes
	// first, so tvalid gets exactly one assignment per edge.
	task automatic send_sample(input logic [CHANNELS-1:0] bits, input logic [TIME_W-1:0] now);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {{(S_DATA_W - TIME_W - CHANNELS){1'b0}}, now, bits};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	// Drop tvalid and hold until every predicted event beat has arrived, then give the
	// pipeline time to settle for samples that produce no event.
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		// the outstanding count is registered, so it trails the last sample beat
		@(posedge clk);
		while (events_waiting != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Only call while the block is idle.
	task automatic write_window(input int value);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= WIN_W'(value);
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
		win = value;
	endtask

	// Mostly advance time by up to two windows plus one so checks land every few samples; now and
	// then repeat the timestamp, jump anywhere, or sit just below the wrap point.
	task automatic random_sample();
		int pick;
		pick = $urandom_range(99);
		if (pick < 5)
			clock_ms = $urandom();
		else if (pick < 9)
			clock_ms = 32'hFFFF_FFFF - TIME_W'($urandom_range(2 * win));
		else if (pick >= 19)
			clock_ms = clock_ms + TIME_W'($urandom_range(2 * win + 1));
		pick = $urandom_range(99);
		if (pick < 40)
			prev_bits = CHANNELS'($urandom_range(63));
		else if (pick < 80)
			prev_bits = CHANNELS'($urandom() & $urandom());
		// otherwise repeat the last pattern so levels settle and checks see no change
		send_sample(prev_bits, clock_ms);
		// rarely hold the sender until the event channel has drained
		if ($urandom_range(99) == 0)
			wait_drained();
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, reset window of 5 ms.
		send_sample(6'h00, 32'd0);            // gap below window: no check
		send_sample(6'h3F, 32'd4);            // latch every channel, still no check
		send_sample(6'h00, 32'd5);            // check: all six enter
		send_sample(6'h00, 32'd10);           // check: all six exit, held 5
		send_sample(6'h15, 32'd14);
		send_sample(6'h2A, 32'd15);           // latches accumulate across samples
		send_sample(6'h2A, 32'd20);           // even channels exit
		send_sample(6'h2A, 32'd25);           // check with no change
		send_sample(6'h3F, 32'hFFFF_FFFE);    // all ones in both fields nearly
		send_sample(6'h00, 32'd3);            // counter wraps: exits with wrapped held time
		send_sample(6'h01, 32'd2);            // time steps back: difference wraps to huge
		wait_drained();

		// Window of zero: every sample qualifies, even with the same timestamp.
		write_window(0);
		send_sample(6'h3F, 32'd2);
		send_sample(6'h00, 32'd2);            // exits with held time zero
		send_sample(6'h3F, 32'hFFFF_FFFF);
		wait_drained();

		// Widest window: one short of it stays quiet, exactly it fires.
		write_window(65535);
		send_sample(6'h15, 32'h0000_FFFD);
		send_sample(6'h00, 32'h0000_FFFE);
		clock_ms = 32'h0000_FFFE;

		// Random part: one window setting and one idling mix per phase.
		for (int phase = 0; phase < 4; phase++) begin
			wait_drained();
			case (phase)
				0: write_window(1);
				1: write_window(65535);
				2: write_window($urandom_range(2, 40));
				default: write_window(WINDOW_RESET);
			endcase
			send_idle_pct  = phase_idle[phase];
			recv_stall_pct = phase_stall[phase];
			for (int n = 0; n < ITEMS_PER_PHASE; n++)
				random_sample();
		end

		wait_drained();
		if (mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	// Watchdog: far beyond the slowest correct run (ns).
	initial begin
		#1_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

@@ windowed_poke_edge_detector.f @@
rtl/core/wpe_pkg.sv
rtl/core/wpe_front.sv
rtl/core/wpe_fifo.sv
rtl/core/wpe_back.sv
rtl/core/windowed_poke_edge_detector.sv
bench/wpe_event_checker.sv
bench/tb_top.sv
